// ----- rtl/ghr_pkg.sv -----
// Shared types and constants for the gamepad event to HID report block.
// Used by ghr_front, ghr_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ghr_pkg;

   // Event kinds on the input channel
   localparam logic [1:0] OP_KEY = 2'd0;
   localparam logic [1:0] OP_ABS = 2'd1;

   // Absolute axis codes
   localparam logic [9:0] AXIS_LX = 10'd0;
   localparam logic [9:0] AXIS_LY = 10'd1;
   localparam logic [9:0] AXIS_LT = 10'd2;
   localparam logic [9:0] AXIS_RX = 10'd3;
   localparam logic [9:0] AXIS_RY = 10'd4;
   localparam logic [9:0] AXIS_RT = 10'd5;

   // Button key codes, in button_mask bit order
   localparam int NUM_BUTTONS = 14;
   localparam logic [9:0] KEY_CODES [NUM_BUTTONS] = '{
      10'h130, 10'h131, 10'h133, 10'h134, 10'h136, 10'h137, 10'h13A,
      10'h13B, 10'h13D, 10'h13E, 10'h220, 10'h221, 10'h222, 10'h223
   };

   // A, B, X and Y together
   localparam logic [NUM_BUTTONS-1:0] COMBO_MASK = 14'h000F;

   // Configuration register indexes and reset values
   localparam logic CSR_DEADZONE  = 1'b0;
   localparam logic CSR_HOLD_TIME = 1'b1;
   localparam logic [6:0]  DEADZONE_RESET  = 7'd10;
   localparam logic [15:0] HOLD_TIME_RESET = 16'd1000;

   // Decoded command kinds passed from front to back
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_KEY   = 2'd1;
   localparam logic [1:0] CMD_STICK = 2'd2;
   localparam logic [1:0] CMD_TRIG  = 2'd3;

   typedef struct packed {
      logic [1:0] kind;   // CMD_* code
      logic [3:0] slot;   // button index, stick index or trigger index
      logic       level;  // key pressed
      logic [7:0] data;   // stick value after deadzone, or trigger level
   } cmd_type;

   typedef struct packed {
      logic [NUM_BUTTONS-1:0] button_mask;
      logic signed [7:0]      left_x;
      logic signed [7:0]      left_y;
      logic signed [7:0]      right_x;
      logic signed [7:0]      right_y;
      logic [7:0]             left_trigger;
      logic [7:0]             right_trigger;
      logic                   reboot_request;
   } report_type;

endpackage

`default_nettype wire

// ----- rtl/ghr_if.sv -----
// Channel interfaces: input events, output reports and register writes.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface ghr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [9:0]         event_code;
   logic signed [31:0] event_value;
   logic [31:0]        time_ms;

   modport source (output valid, operation, event_code, event_value, time_ms, input ready);
   modport sink   (input valid, operation, event_code, event_value, time_ms, output ready);
endinterface

interface ghr_rsp_if;
   logic              valid;
   logic              ready;
   logic [13:0]       button_mask;
   logic signed [7:0] left_x;
   logic signed [7:0] left_y;
   logic signed [7:0] right_x;
   logic signed [7:0] right_y;
   logic [7:0]        left_trigger;
   logic [7:0]        right_trigger;
   logic              reboot_request;

   modport source (output valid, button_mask, left_x, left_y, right_x, right_y,
                   left_trigger, right_trigger, reboot_request, input ready);
   modport sink   (input valid, button_mask, left_x, left_y, right_x, right_y,
                   left_trigger, right_trigger, reboot_request, output ready);
endinterface

interface ghr_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ghr_front.sv -----
// Front end: accepts an input event, decodes its code and applies the deadzone.
// Depends on ghr_pkg for codes and the command type.
`timescale 1ns / 1ps
`default_nettype none

module ghr_front #(
   parameter int TIMESTAMP_BITS = 32
) (
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic [1:0]                operation,
   input  wire logic [9:0]                event_code,
   input  wire logic signed [31:0]        event_value,
   input  wire logic [31:0]               time_ms,
   input  wire logic [6:0]                deadzone,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output ghr_pkg::cmd_type               out_cmd,
   output logic [TIMESTAMP_BITS-1:0]      out_now
);

   logic              key_hit;
   logic [3:0]        key_idx;
   logic [7:0]        hi_byte;
   logic signed [8:0] stick_s;
   logic signed [8:0] dz_s;
   logic              in_dead;
   logic [7:0]        stick_val;

   // Pass the handshake straight to the queue
   assign in_ready  = out_ready;
   assign out_valid = in_valid;
   assign out_now   = TIMESTAMP_BITS'(time_ms);

   // Match the key code against the button table
   always_comb begin
      key_hit = 1'b0;
      key_idx = 4'd0;
      for (int i = 0; i < ghr_pkg::NUM_BUTTONS; i++) begin
         if (event_code == ghr_pkg::KEY_CODES[i]) begin
            key_hit = 1'b1;
            key_idx = 4'(i);
         end
      end
   end

   // Zero a stick value inside the deadzone
   assign hi_byte   = event_value[15:8];
   assign stick_s   = {hi_byte[7], hi_byte};
   assign dz_s      = {2'b00, deadzone};
   assign in_dead   = (stick_s > -dz_s) && (stick_s < dz_s);
   assign stick_val = in_dead ? 8'd0 : hi_byte;

   // Classify the event
   always_comb begin
      out_cmd       = '0;
      out_cmd.kind  = ghr_pkg::CMD_NONE;
      out_cmd.level = (event_value != 32'sd0);
      case (operation)
         ghr_pkg::OP_KEY: begin
            if (key_hit) begin
               out_cmd.kind = ghr_pkg::CMD_KEY;
               out_cmd.slot = key_idx;
            end
         end
         ghr_pkg::OP_ABS: begin
            case (event_code)
               ghr_pkg::AXIS_LX: begin
                  out_cmd.kind = ghr_pkg::CMD_STICK;
                  out_cmd.slot = 4'd0;
                  out_cmd.data = stick_val;
               end
               ghr_pkg::AXIS_LY: begin
                  out_cmd.kind = ghr_pkg::CMD_STICK;
                  out_cmd.slot = 4'd1;
                  out_cmd.data = stick_val;
               end
               ghr_pkg::AXIS_RX: begin
                  out_cmd.kind = ghr_pkg::CMD_STICK;
                  out_cmd.slot = 4'd2;
                  out_cmd.data = stick_val;
               end
               ghr_pkg::AXIS_RY: begin
                  out_cmd.kind = ghr_pkg::CMD_STICK;
                  out_cmd.slot = 4'd3;
                  out_cmd.data = stick_val;
               end
               ghr_pkg::AXIS_LT: begin
                  out_cmd.kind = ghr_pkg::CMD_TRIG;
                  out_cmd.slot = 4'd0;
                  out_cmd.data = event_value[7:0];
               end
               ghr_pkg::AXIS_RT: begin
                  out_cmd.kind = ghr_pkg::CMD_TRIG;
                  out_cmd.slot = 4'd1;
                  out_cmd.data = event_value[7:0];
               end
               default: begin
                  out_cmd.kind = ghr_pkg::CMD_NONE;
               end
            endcase
         end
         default: begin
            out_cmd.kind = ghr_pkg::CMD_NONE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/ghr_queue.sv -----
// Small register FIFO between the front and back ends.
// Generic; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module ghr_queue #(
   parameter int Width = 16,
   parameter int Depth = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [Width-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [Width-1:0]      pop_data
);

   localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);

   logic [Width-1:0]  mem_ff [Depth];
   logic [AddrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != CountW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AddrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ghr_back.sv -----
// Back end: applies decoded commands to the pad state, runs the hold timer
// and registers the report. Depends on ghr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ghr_back #(
   parameter int TIMESTAMP_BITS = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       cmd_valid,
   output logic                            cmd_ready,
   input  wire ghr_pkg::cmd_type           cmd,
   input  wire logic [TIMESTAMP_BITS-1:0]  now,
   input  wire logic [15:0]                hold_time_ms,
   output logic                            rpt_valid,
   input  wire logic                       rpt_ready,
   output ghr_pkg::report_type             rpt
);

   localparam int NB = ghr_pkg::NUM_BUTTONS;

   logic [NB-1:0]             buttons_ff, buttons_in;
   logic [7:0]                stick_ff [4];
   logic [7:0]                stick_in [4];
   logic [7:0]                trig_ff [2];
   logic [7:0]                trig_in [2];
   logic                      holding_ff, holding_in;
   logic [TIMESTAMP_BITS-1:0] start_ff, start_in;
   logic [TIMESTAMP_BITS-1:0] elapsed;
   logic                      combo;
   logic                      reboot;
   logic                      rpt_valid_ff, rpt_valid_in;
   ghr_pkg::report_type       rpt_ff;
   logic                      take;

   // Take a command when the report register is free or being drained
   assign take      = cmd_valid && (!rpt_valid_ff || rpt_ready);
   assign cmd_ready = !rpt_valid_ff || rpt_ready;

   // Apply the command to the pad state
   always_comb begin
      buttons_in = buttons_ff;
      stick_in   = stick_ff;
      trig_in    = trig_ff;
      case (cmd.kind)
         ghr_pkg::CMD_KEY: begin
            buttons_in[cmd.slot] = cmd.level;
         end
         ghr_pkg::CMD_STICK: begin
            stick_in[cmd.slot[1:0]] = cmd.data;
         end
         ghr_pkg::CMD_TRIG: begin
            trig_in[cmd.slot[0]] = cmd.data;
         end
         default: begin
            buttons_in = buttons_ff;
         end
      endcase
   end

   // Hold timer on A, B, X and Y
   assign combo   = ((buttons_in & ghr_pkg::COMBO_MASK) == ghr_pkg::COMBO_MASK);
   assign elapsed = now - start_ff;

   always_comb begin
      holding_in = 1'b0;
      start_in   = '0;
      reboot     = 1'b0;
      if (combo) begin
         holding_in = 1'b1;
         if (holding_ff) begin
            start_in = start_ff;
            reboot   = (elapsed > TIMESTAMP_BITS'(hold_time_ms));
         end else begin
            start_in = now;
         end
      end
   end

   // Hold a finished report until the sink takes it
   always_comb begin
      rpt_valid_in = rpt_valid_ff;
      if (take) begin
         rpt_valid_in = 1'b1;
      end else if (rpt_ready) begin
         rpt_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buttons_ff   <= '0;
         stick_ff     <= '{default: 8'd0};
         trig_ff      <= '{default: 8'd0};
         holding_ff   <= 1'b0;
         start_ff     <= '0;
         rpt_valid_ff <= 1'b0;
      end else begin
         rpt_valid_ff <= rpt_valid_in;
         if (take) begin
            buttons_ff <= buttons_in;
            stick_ff   <= stick_in;
            trig_ff    <= trig_in;
            holding_ff <= holding_in;
            start_ff   <= start_in;
         end
      end
   end

   // Report payload register
   always_ff @(posedge clock) begin
      if (take) begin
         rpt_ff.button_mask    <= buttons_in;
         rpt_ff.left_x         <= stick_in[0];
         rpt_ff.left_y         <= stick_in[1];
         rpt_ff.right_x        <= stick_in[2];
         rpt_ff.right_y        <= stick_in[3];
         rpt_ff.left_trigger   <= trig_in[0];
         rpt_ff.right_trigger  <= trig_in[1];
         rpt_ff.reboot_request <= reboot;
      end
   end

   assign rpt_valid = rpt_valid_ff;
   assign rpt       = rpt_ff;

endmodule

`default_nettype wire

// ----- rtl/gamepad_event_to_hid_report.sv -----
// Top level: gamepad event to HID report converter.
// Depends on ghr_pkg, ghr_if, ghr_front, ghr_queue and ghr_back.
//
//   Channel    Dir  Handshake        Carries
//   req_chan   in   valid / ready    operation, event_code, event_value, time_ms
//   rsp_chan   out  valid / ready    button_mask, sticks, triggers, reboot_request
//   csr_chan   in   valid / ready    index (0 deadzone, 1 hold_time_ms), data
//
// One event in per cycle, one report out per cycle, sustained while the sink takes reports.
// An accepted event first enters the two-entry command queue, then moves into the
// report register when the back end takes it; the report is valid once it is there.
// Reset clears the pad state and the queue and empties the report register; the
// deadzone and hold time return to 10 and 1000. A stalled report holds the
// back end, and the front keeps taking events until the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_event_to_hid_report #(
   parameter int TIMESTAMP_BITS = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ghr_req_if.sink    req_chan,
   ghr_rsp_if.source  rsp_chan,
   ghr_csr_if.sink    csr_chan
);

   localparam int QueueW = $bits(ghr_pkg::cmd_type) + TIMESTAMP_BITS;

   logic [6:0]                deadzone_ff, deadzone_in;
   logic [15:0]               hold_time_ff, hold_time_in;
   logic                      fr_valid;
   logic                      fr_ready;
   ghr_pkg::cmd_type          fr_cmd;
   logic [TIMESTAMP_BITS-1:0] fr_now;
   logic                      bk_valid;
   logic                      bk_ready;
   logic [QueueW-1:0]         bk_data;
   ghr_pkg::cmd_type          bk_cmd;
   logic [TIMESTAMP_BITS-1:0] bk_now;
   ghr_pkg::report_type       rpt;

   // Configuration registers
   assign csr_chan.ready = 1'b1;

   always_comb begin
      deadzone_in  = deadzone_ff;
      hold_time_in = hold_time_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            ghr_pkg::CSR_DEADZONE:  deadzone_in  = csr_chan.data[6:0];
            ghr_pkg::CSR_HOLD_TIME: hold_time_in = csr_chan.data;
            default:                deadzone_in  = deadzone_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff  <= ghr_pkg::DEADZONE_RESET;
         hold_time_ff <= ghr_pkg::HOLD_TIME_RESET;
      end else begin
         deadzone_ff  <= deadzone_in;
         hold_time_ff <= hold_time_in;
      end
   end

   // Decode events
   ghr_front #(
      .TIMESTAMP_BITS (TIMESTAMP_BITS)
   ) u_front (
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .operation   (req_chan.operation),
      .event_code  (req_chan.event_code),
      .event_value (req_chan.event_value),
      .time_ms     (req_chan.time_ms),
      .deadzone    (deadzone_ff),
      .out_valid   (fr_valid),
      .out_ready   (fr_ready),
      .out_cmd     (fr_cmd),
      .out_now     (fr_now)
   );

   // Decouple front and back
   ghr_queue #(
      .Width (QueueW),
      .Depth (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  ({fr_cmd, fr_now}),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready),
      .pop_data   (bk_data)
   );

   assign bk_cmd = bk_data[QueueW-1:TIMESTAMP_BITS];
   assign bk_now = bk_data[TIMESTAMP_BITS-1:0];

   // Update state and build reports
   ghr_back #(
      .TIMESTAMP_BITS (TIMESTAMP_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (bk_valid),
      .cmd_ready    (bk_ready),
      .cmd          (bk_cmd),
      .now          (bk_now),
      .hold_time_ms (hold_time_ff),
      .rpt_valid    (rsp_chan.valid),
      .rpt_ready    (rsp_chan.ready),
      .rpt          (rpt)
   );

   assign rsp_chan.button_mask    = rpt.button_mask;
   assign rsp_chan.left_x         = rpt.left_x;
   assign rsp_chan.left_y         = rpt.left_y;
   assign rsp_chan.right_x        = rpt.right_x;
   assign rsp_chan.right_y        = rpt.right_y;
   assign rsp_chan.left_trigger   = rpt.left_trigger;
   assign rsp_chan.right_trigger  = rpt.right_trigger;
   assign rsp_chan.reboot_request = rpt.reboot_request;

endmodule

`default_nettype wire

// ----- rtl/ghr_checker.sv -----
// Port-level checks on the report channel, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none

module ghr_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [13:0]       rsp_button_mask,
   input wire logic signed [7:0] rsp_left_x,
   input wire logic signed [7:0] rsp_left_y,
   input wire logic signed [7:0] rsp_right_x,
   input wire logic signed [7:0] rsp_right_y,
   input wire logic [7:0]        rsp_left_trigger,
   input wire logic [7:0]        rsp_right_trigger,
   input wire logic              rsp_reboot_request
);

   // A stalled report stays offered
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("report dropped while stalled");

   // A stalled report keeps its contents
   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_button_mask) && $stable(rsp_left_x)
         && $stable(rsp_left_y) && $stable(rsp_right_x) && $stable(rsp_right_y)
         && $stable(rsp_left_trigger) && $stable(rsp_right_trigger)
         && $stable(rsp_reboot_request))
      else $error("report changed while stalled");

   // Reset empties the report register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("report valid after reset");

   // A reboot request only comes with A, B, X and Y all held
   a_reboot_combo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reboot_request |-> (rsp_button_mask[3:0] == 4'hF))
      else $error("reboot request without the face-button combo");

endmodule

bind gamepad_event_to_hid_report ghr_checker u_ghr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_button_mask    (rsp_chan.button_mask),
   .rsp_left_x         (rsp_chan.left_x),
   .rsp_left_y         (rsp_chan.left_y),
   .rsp_right_x        (rsp_chan.right_x),
   .rsp_right_y        (rsp_chan.right_y),
   .rsp_left_trigger   (rsp_chan.left_trigger),
   .rsp_right_trigger  (rsp_chan.right_trigger),
   .rsp_reboot_request (rsp_chan.reboot_request)
);

`default_nettype wire
